### rtl/telnet_option_responder_unit_macros.svh
// assertion macros for the telnet option responder
// used by tor_fifo and tor_back; expects clk_i and rst_ni in scope
`ifndef TELNET_OPTION_RESPONDER_UNIT_MACROS_SVH
`define TELNET_OPTION_RESPONDER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TOR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TOR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define TOR_ASSERT(lbl, prop, msg)

`define TOR_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

### rtl/tor_pkg.sv
// types, constants and the reply byte table of the telnet option responder
// no dependencies
`default_nettype none

package tor_pkg;

  localparam logic [7:0] IAC_BYTE  = 8'd255;
  localparam logic [7:0] CMD_WILL  = 8'd251;
  localparam logic [7:0] CMD_WONT  = 8'd252;
  localparam logic [7:0] CMD_DO    = 8'd253;
  localparam logic [7:0] CMD_DONT  = 8'd254;
  localparam logic [7:0] CMD_SB    = 8'd250;
  localparam logic [7:0] CMD_SE    = 8'd240;
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;

  localparam int unsigned TtypeLen = 10;
  localparam int unsigned IdxW     = 4;

  localparam logic [7:0] TTYPE_REPLY [TtypeLen] = '{
    8'd255, 8'd250, 8'd24, 8'd0, 8'd65, 8'd78, 8'd83, 8'd73, 8'd255, 8'd240
  };

  localparam logic [IdxW-1:0] REPLY_LAST_IDX = IdxW'(2);
  localparam logic [IdxW-1:0] TTYPE_LAST_IDX = IdxW'(TtypeLen - 1);

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_REPLY,
    KIND_TTYPE
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_remote;
    logic       last;
  } out_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] cmd;
    logic [7:0] opt;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic out_item_t entry_byte(entry_t e, logic [IdxW-1:0] idx);
    out_item_t r;
    r = '0;
    case (e.kind)
      KIND_DATA: begin
        r.out_byte  = e.opt;
        r.to_remote = 1'b0;
        r.last      = 1'b1;
      end
      KIND_REPLY: begin
        r.to_remote = 1'b1;
        r.last      = (idx == REPLY_LAST_IDX);
        if (idx == IdxW'(0)) begin
          r.out_byte = IAC_BYTE;
        end else if (idx == IdxW'(1)) begin
          r.out_byte = e.cmd;
        end else begin
          r.out_byte = e.opt;
        end
      end
      KIND_TTYPE: begin
        r.to_remote = 1'b1;
        r.last      = (idx == TTYPE_LAST_IDX);
        r.out_byte  = TTYPE_REPLY[idx];
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/telnet_option_responder_unit.sv
// telnet option responder: received bytes in, display bytes and replies out
// jobs from accepted bytes pass through the job queue and then the output register
// throughput: one input per cycle; a plain byte gives one output byte, an option reply
// three, a terminal-type reply ten; input stalls only while the job queue is full
// reset: asynchronous active low, parser back to normal data, queue and output empty
// depends on tor_pkg, tor_front, tor_fifo and tor_back
`default_nettype none

module telnet_option_responder_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tor_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tor_pkg::out_item_t      out_item_o
);

  logic            full;
  logic            push;
  logic            pop;
  tor_pkg::entry_t entry;
  tor_pkg::head_t  head;

  assign in_ready_o = !full;

  tor_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_valid_i && in_ready_o),
    .item_i   (in_item_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  tor_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  tor_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### rtl/tor_front.sv
// front end: telnet parser that classifies received bytes into display and reply jobs
// depends on tor_pkg
`default_nettype none

module tor_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire tor_pkg::in_item_t item_i,
  output logic                   push_o,
  output tor_pkg::entry_t        entry_o
);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_OPT  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] b;
  logic       sb_done;
  logic       job;

  assign b       = item_i.rx_byte;
  assign sb_done = (b == tor_pkg::CMD_SE) || item_i.chunk_end;

  always_comb begin
    phase_d       = phase_q;
    held_d        = held_q;
    job           = 1'b0;
    entry_o.kind  = tor_pkg::KIND_DATA;
    entry_o.cmd   = tor_pkg::CMD_WONT;
    entry_o.opt   = b;
    case (phase_q)
      PH_DATA: begin
        if (b == tor_pkg::IAC_BYTE) begin
          phase_d = PH_CMD;
        end else begin
          job = 1'b1;
        end
      end
      PH_CMD: begin
        held_d  = b;
        phase_d = PH_OPT;
      end
      PH_OPT: begin
        phase_d      = PH_DATA;
        entry_o.kind = tor_pkg::KIND_REPLY;
        if (held_q == tor_pkg::CMD_DO &&
            (b == tor_pkg::OPT_SGA || b == tor_pkg::OPT_TTYPE)) begin
          job         = 1'b1;
          entry_o.cmd = tor_pkg::CMD_WILL;
        end else if (held_q == tor_pkg::CMD_WILL || held_q == tor_pkg::CMD_WONT) begin
          job = 1'b1;
          if (b inside {tor_pkg::OPT_ECHO, tor_pkg::OPT_SGA, tor_pkg::OPT_TTYPE}) begin
            entry_o.cmd = tor_pkg::CMD_DO;
          end else begin
            entry_o.cmd = tor_pkg::CMD_DONT;
          end
        end else if (held_q == tor_pkg::CMD_DO || held_q == tor_pkg::CMD_DONT) begin
          job         = 1'b1;
          entry_o.cmd = tor_pkg::CMD_WONT;
        end else if (held_q == tor_pkg::CMD_SB) begin
          entry_o.kind = tor_pkg::KIND_TTYPE;
          if (sb_done) begin
            job = 1'b1;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        entry_o.kind = tor_pkg::KIND_TTYPE;
        if (sb_done) begin
          job     = 1'b1;
          phase_d = PH_DATA;
        end
      end
      default: begin
        phase_d = PH_DATA;
      end
    endcase
  end

  assign push_o = accept_i && job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DATA;
      held_q  <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

### rtl/tor_fifo.sv
// job queue between the parser and the byte sequencer
// depends on tor_pkg and the assertion macro header
`default_nettype none
`include "telnet_option_responder_unit_macros.svh"

module tor_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tor_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output tor_pkg::head_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tor_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != CntW'(0));
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? PtrW'(0) : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `TOR_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")
  `TOR_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + CntW'(1), "queue count did not grow on push")

endmodule

`default_nettype wire

### rtl/tor_back.sv
// back end: expands queued jobs into result bytes through an output register
// depends on tor_pkg and the assertion macro header
`default_nettype none
`include "telnet_option_responder_unit_macros.svh"

module tor_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tor_pkg::head_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tor_pkg::out_item_t  out_item_o
);

  tor_pkg::entry_t           cur_q, cur_d;
  logic                      busy_q, busy_d;
  logic [tor_pkg::IdxW-1:0]  cnt_q, cnt_d;
  logic                      valid_q, valid_d;
  tor_pkg::out_item_t        out_q, out_d;
  logic                      advance;
  tor_pkg::out_item_t        nb;

  assign advance = !valid_q || out_ready_i;

  always_comb begin
    cur_d   = cur_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    out_d   = out_q;
    pop_o   = 1'b0;
    nb      = '0;
    if (advance) begin
      if (busy_q) begin
        nb      = tor_pkg::entry_byte(cur_q, cnt_q);
        out_d   = nb;
        valid_d = 1'b1;
        if (nb.last) begin
          busy_d = 1'b0;
        end else begin
          cnt_d = cnt_q + tor_pkg::IdxW'(1);
        end
      end else if (head_i.valid) begin
        pop_o   = 1'b1;
        nb      = tor_pkg::entry_byte(head_i.entry, '0);
        out_d   = nb;
        valid_d = 1'b1;
        if (!nb.last) begin
          busy_d = 1'b1;
          cnt_d  = tor_pkg::IdxW'(1);
          cur_d  = head_i.entry;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = out_q;

  `TOR_ASSERT(a_busy_cnt, !busy_q || (cnt_q != '0 && cnt_q <= tor_pkg::TTYPE_LAST_IDX), "sequencer index out of range")
  `TOR_ASSERT(a_no_pop_busy, !(pop_o && busy_q), "job popped while a reply is still in flight")

endmodule

`default_nettype wire
